// ===== design/tilt_pkg.sv =====
`default_nettype none

package tilt_pkg;

  // field widths of the request and result
  localparam int RAW_W      = 16;
  localparam int AXIS_SHIFT = 6;
  localparam int AXIS_W     = RAW_W - AXIS_SHIFT;
  localparam int ANGLE_W    = 16;

  // datapath widths
  localparam int SQ_W       = 2 * AXIS_W - 1;
  localparam int SUM_W      = SQ_W + 1;
  localparam int FRAC_W     = 16;
  localparam int RAD_W      = SUM_W + FRAC_W;
  localparam int ROOT_STEPS = RAD_W / 2;
  localparam int ROOT_W     = ROOT_STEPS;
  localparam int CORD_W     = 21;
  localparam int ACC_W      = 24;
  localparam int TAB_W      = 23;
  localparam int TABLE_LEN  = 24;

  // +90 degrees, in 1/256 and 1/65536 degree
  localparam logic [ANGLE_W-1:0] ANGLE_MAX     = 16'd23040;
  localparam logic [TAB_W-1:0]   ANGLE_MAX_Q16 = 23'd5898240;
  localparam logic [TAB_W-1:0]   ROUND_HALF    = 23'd128;

  // atan(2^-i) in degrees, scaled by 65536
  localparam logic [TAB_W-1:0] ATAN_DEG_Q16 [TABLE_LEN] = '{
    23'd2949120, 23'd1740967, 23'd919879, 23'd466945, 23'd234379, 23'd117304,
    23'd58666,   23'd29335,   23'd14668,  23'd7334,   23'd3667,   23'd1833,
    23'd917,     23'd458,     23'd229,    23'd115,    23'd57,     23'd29,
    23'd14,      23'd7,       23'd4,      23'd2,      23'd1,      23'd0
  };

  typedef struct packed {
    logic signed [RAW_W-1:0] x_raw;
    logic signed [RAW_W-1:0] y_raw;
    logic signed [RAW_W-1:0] z_raw;
  } tilt_in_t;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] tilt_angle;
    logic                      angle_invalid;
  } tilt_out_t;

  // special-case flags carried down the pipe
  typedef struct packed {
    logic zneg;
    logic zzero;
    logic szero;
  } tilt_flags_t;

  typedef struct packed {
    logic [SQ_W-1:0]   xx;
    logic [SQ_W-1:0]   yy;
    logic [AXIS_W-1:0] az;
    logic              zneg;
    logic              zzero;
  } tilt_sq_t;

  typedef struct packed {
    logic [RAD_W-1:0]  rem;
    logic [RAD_W-1:0]  root;
    logic [AXIS_W-1:0] az;
    tilt_flags_t       flags;
  } tilt_rad_t;

  typedef struct packed {
    logic signed [CORD_W-1:0] cx;
    logic signed [CORD_W-1:0] cy;
    logic signed [ACC_W-1:0]  ang;
    tilt_flags_t              flags;
  } tilt_cord_t;

endpackage

`default_nettype wire

// ===== design/accelerometer_tilt_angle.sv =====
`default_nettype none

// channel   ports                          content
// request   in_valid  in_stall  in_data    three raw axis words
// result    out_valid out_stall out_data   tilt angle, invalid flag
//
// one request enters per cycle while in_stall is low; the pipe has one square
// stage, one sum stage, 18 square-root digit stages, one stage per CORDIC
// rotation (min(CORDIC_STEPS, 24) of them) and one rounding stage.
// rst_n clears every stage valid bit; payload registers are not reset.
// each stage holds while it is full and the stage after it is held, so a
// stall on out_stall fills bubbles first and loses or repeats nothing.

module accelerometer_tilt_angle #(
  parameter int CORDIC_STEPS = 16
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  wire tilt_pkg::tilt_in_t in_data,
  output logic                 out_valid,
  input  wire                  out_stall,
  output tilt_pkg::tilt_out_t  out_data
);

  import tilt_pkg::*;

  localparam int NSTEPS   = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;
  localparam int RAD_BASE = 1;
  localparam int CORD_BASE = RAD_BASE + ROOT_STEPS + 1;
  localparam int ST       = CORD_BASE + NSTEPS + 1;

  logic [ST-1:0] valid_r;
  logic [ST:0]   st_ready;
  logic [ST-1:0] vin;

  tilt_sq_t   sq_r;
  tilt_rad_t  rad_r  [ROOT_STEPS+1];
  tilt_cord_t cord_r [NSTEPS];
  tilt_cord_t cord_in [NSTEPS];
  tilt_out_t  out_r;

  // stage handshake: a stage takes new data when empty or moving on
  always_comb begin
    st_ready[ST] = !out_stall;
    for (int k = ST - 1; k >= 0; k--) begin
      st_ready[k] = !valid_r[k] || st_ready[k+1];
    end
  end

  assign vin      = {valid_r[ST-2:0], in_valid};
  assign in_stall = !st_ready[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      for (int k = 0; k < ST; k++) begin
        if (st_ready[k]) begin
          valid_r[k] <= vin[k];
        end
      end
    end
  end

  // axis extraction and squares
  logic signed [AXIS_W-1:0]   x_ax, y_ax, z_ax;
  logic signed [2*AXIS_W-1:0] xx_full, yy_full;
  tilt_sq_t                   sq_nxt;

  always_comb begin
    x_ax    = $signed(in_data.x_raw[RAW_W-1:AXIS_SHIFT]);
    y_ax    = $signed(in_data.y_raw[RAW_W-1:AXIS_SHIFT]);
    z_ax    = $signed(in_data.z_raw[RAW_W-1:AXIS_SHIFT]);
    xx_full = x_ax * x_ax;
    yy_full = y_ax * y_ax;
    sq_nxt.xx    = xx_full[SQ_W-1:0];
    sq_nxt.yy    = yy_full[SQ_W-1:0];
    sq_nxt.az    = z_ax[AXIS_W-1] ? AXIS_W'(~z_ax + 1'b1) : AXIS_W'(z_ax);
    sq_nxt.zneg  = z_ax[AXIS_W-1];
    sq_nxt.zzero = (z_ax == '0);
  end

  always_ff @(posedge clk) begin
    if (st_ready[0]) begin
      sq_r <= sq_nxt;
    end
  end

  // sum of squares, scaled to Q.16 for the root
  logic [SUM_W-1:0] s_sum;
  tilt_rad_t        rad0_nxt;

  always_comb begin
    s_sum = SUM_W'(sq_r.xx) + SUM_W'(sq_r.yy);
    rad0_nxt.rem         = {s_sum, FRAC_W'(0)};
    rad0_nxt.root        = '0;
    rad0_nxt.az          = sq_r.az;
    rad0_nxt.flags.zneg  = sq_r.zneg;
    rad0_nxt.flags.zzero = sq_r.zzero;
    rad0_nxt.flags.szero = (s_sum == '0);
  end

  always_ff @(posedge clk) begin
    if (st_ready[RAD_BASE]) begin
      rad_r[0] <= rad0_nxt;
    end
  end

  // square root, one result bit per stage
  for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_root
    localparam logic [RAD_W-1:0] BIT_K = RAD_W'(1) << (RAD_W - 2 - 2 * k);
    logic [RAD_W:0] trial;
    tilt_rad_t      rad_nxt;

    always_comb begin
      trial   = {1'b0, rad_r[k].root} + {1'b0, BIT_K};
      rad_nxt = rad_r[k];
      if ({1'b0, rad_r[k].rem} >= trial) begin
        rad_nxt.rem  = rad_r[k].rem - trial[RAD_W-1:0];
        rad_nxt.root = (rad_r[k].root >> 1) + BIT_K;
      end else begin
        rad_nxt.root = rad_r[k].root >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (st_ready[RAD_BASE+1+k]) begin
        rad_r[k+1] <= rad_nxt;
      end
    end
  end

  // CORDIC start vector: (|z| in Q.8, root)
  always_comb begin
    cord_in[0].cx    = $signed({(CORD_W-AXIS_W-8)'(0), rad_r[ROOT_STEPS].az, 8'd0});
    cord_in[0].cy    = $signed({(CORD_W-ROOT_W)'(0),
                                rad_r[ROOT_STEPS].root[ROOT_W-1:0]});
    cord_in[0].ang   = '0;
    cord_in[0].flags = rad_r[ROOT_STEPS].flags;
  end

  // vectoring rotations, one per stage
  for (genvar i = 0; i < NSTEPS; i++) begin : g_cord
    logic signed [CORD_W-1:0] dx, dy;
    logic signed [ACC_W-1:0]  step_ang;
    tilt_cord_t               cord_nxt;

    if (i > 0) begin : g_link
      assign cord_in[i] = cord_r[i-1];
    end

    always_comb begin
      dx       = cord_in[i].cy >>> i;
      dy       = cord_in[i].cx >>> i;
      step_ang = $signed({(ACC_W-TAB_W)'(0), ATAN_DEG_Q16[i]});
      cord_nxt = cord_in[i];
      if (cord_in[i].cy > 0) begin
        cord_nxt.cx  = cord_in[i].cx + dx;
        cord_nxt.cy  = cord_in[i].cy - dy;
        cord_nxt.ang = cord_in[i].ang + step_ang;
      end else begin
        cord_nxt.cx  = cord_in[i].cx - dx;
        cord_nxt.cy  = cord_in[i].cy + dy;
        cord_nxt.ang = cord_in[i].ang - step_ang;
      end
    end

    always_ff @(posedge clk) begin
      if (st_ready[CORD_BASE+i]) begin
        cord_r[i] <= cord_nxt;
      end
    end
  end

  // clamp, round to 1/256 degree, apply sign and special cases
  logic signed [ACC_W-1:0] ang_fin;
  tilt_flags_t             fl_fin;
  logic [TAB_W-1:0]        ang_clip;
  logic [TAB_W:0]          ang_rnd;
  logic [ANGLE_W-1:0]      mag;
  tilt_out_t               out_nxt;

  always_comb begin
    ang_fin = cord_r[NSTEPS-1].ang;
    fl_fin  = cord_r[NSTEPS-1].flags;
    if (ang_fin < 0) begin
      ang_clip = '0;
    end else if (ang_fin > $signed({1'b0, ANGLE_MAX_Q16})) begin
      ang_clip = ANGLE_MAX_Q16;
    end else begin
      ang_clip = ang_fin[TAB_W-1:0];
    end
    ang_rnd = {1'b0, ang_clip} + {1'b0, ROUND_HALF};
    mag     = ANGLE_W'(ang_rnd[TAB_W:8]);
    out_nxt.angle_invalid = fl_fin.szero && fl_fin.zzero;
    priority if (fl_fin.szero) begin
      out_nxt.tilt_angle = '0;
    end else if (fl_fin.zzero) begin
      out_nxt.tilt_angle = $signed(ANGLE_MAX);
    end else if (fl_fin.zneg) begin
      out_nxt.tilt_angle = $signed(~mag + 1'b1);
    end else begin
      out_nxt.tilt_angle = $signed(mag);
    end
  end

  always_ff @(posedge clk) begin
    if (st_ready[ST-1]) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = valid_r[ST-1];
  assign out_data  = out_r;

endmodule

`default_nettype wire
